FILE: hdl/brf_pkg.sv
// Shared constants and types for the byte ring FIFO with search.
package brf_pkg;

   localparam int unsigned DEPTH_DEFAULT = 16384;
   localparam int unsigned DEFAULT_LEN   = 10240;
   localparam int unsigned RESET_LEN     = 16384;

   typedef enum logic [2:0] {
      CMD_PUSH    = 3'd0,
      CMD_POP     = 3'd1,
      CMD_PEEK    = 3'd2,
      CMD_DISCARD = 3'd3,
      CMD_SKIP    = 3'd4,
      CMD_SEARCH  = 3'd5
   } cmd_type;

   // Decoded command as it travels from the front part to the back part.
   typedef struct packed {
      logic [2:0]  cmd;
      logic [7:0]  data_in;
      logic [14:0] count;
      logic [31:0] pattern;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

FILE: hdl/brf_cmd_queue.sv
// Short command queue between the front part and the execution engine.
module brf_cmd_queue
   import brf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   output logic      full,
   input  logic      pop,
   output entry_type pop_data,
   output logic      empty
);

   entry_type   slot_ff [2];
   entry_type   slot_in [2];
   logic [1:0]  cnt_ff, cnt_in;
   logic        do_push, do_pop;

   assign full     = (cnt_ff == 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign pop_data = slot_ff[0];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      slot_in[0] = slot_ff[0];
      slot_in[1] = slot_ff[1];
      cnt_in     = cnt_ff;
      if (do_pop) begin
         slot_in[0] = slot_ff[1];
         cnt_in     = cnt_in - 2'd1;
      end
      if (do_push) begin
         if ((do_pop ? cnt_ff - 2'd1 : cnt_ff) == 2'd0) begin
            slot_in[0] = push_data;
         end else begin
            slot_in[1] = push_data;
         end
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      slot_ff[0] <= slot_in[0];
      slot_ff[1] <= slot_in[1];
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> full)
      else $error("full queue lost an entry without a pop");
   assert property (@(posedge clock) disable iff (reset)
      empty && !push |=> empty)
      else $error("empty queue gained an entry without a push");

endmodule

FILE: hdl/brf_engine.sv
// Execution engine: ring indexes, byte memory, search sequencer, result register.
module brf_engine
   import brf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [14:0] csr_wdata,
   input  entry_type   cmd_data,
   input  logic        cmd_empty,
   output logic        cmd_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_ok,
   output logic [14:0] rsp_amount,
   output logic [13:0] rsp_used_count,
   output logic [13:0] rsp_free_count,
   output logic        busy
);

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned SW = AW + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_READ, ST_SEARCH, ST_SDRAIN, ST_DONE
   } state_type;

   logic [7:0]   mem [DEPTH];
   logic [7:0]   rd_q;
   logic [AW-1:0] rd_addr;

   state_type    state_ff;
   logic [SW-1:0] size_ff, wr_ff, rd_ff;
   logic [SW-1:0] used;
   entry_type    cur_ff;
   logic [SW-1:0] scan_ff;     // match candidate index
   logic [SW-1:0] fetch_ff;    // next offset to read
   logic [1:0]   mcnt_ff;      // matched bytes so far
   logic [SW-1:0] lim_ff;
   logic         out_v_ff;
   logic [7:0]   o_dat_ff;
   logic         o_ok_ff;
   logic [14:0]  o_amt_ff;
   logic         rd_v_ff;

   assign rsp_empty      = !out_v_ff;
   assign rsp_data_out   = o_dat_ff;
   assign rsp_ok         = o_ok_ff;
   assign rsp_amount     = o_amt_ff;
   assign busy           = (state_ff != ST_IDLE) || !cmd_empty;

   function automatic logic [SW-1:0] radd(input logic [SW-1:0] a, input logic [SW:0] b,
                                          input logic [SW-1:0] sz);
      logic [SW+1:0] s;
      s = {2'b0, a} + {1'b0, b};
      if (s >= {2'b0, sz}) s = s - {2'b0, sz};
      return s[SW-1:0];
   endfunction

   function automatic logic [SW-1:0] fit(input logic [14:0] v);
      logic [31:0] w;
      w = {17'd0, v};
      if (w == 0) w = DEFAULT_LEN;
      if (w < 2) w = 2;
      if (w > DEPTH) w = DEPTH;
      return w[SW-1:0];
   endfunction

   assign used = (wr_ff >= rd_ff) ? wr_ff - rd_ff : wr_ff + size_ff - rd_ff;

   logic [SW-1:0] used_o, free_o;
   assign used_o = used;
   assign free_o = size_ff - 1'b1 - used;

   logic [SW:0] cnt_ext;
   assign cnt_ext = (SW + 1 >= 15) ? (SW + 1)'(cmd_data.count) : (SW + 1)'(cmd_data.count);

   logic cnt_lt_used, cnt_le_used;
   assign cnt_lt_used = {17'd0, cmd_data.count} < {{(32 - SW){1'b0}}, used};
   assign cnt_le_used = {17'd0, cmd_data.count} <= {{(32 - SW){1'b0}}, used};

   logic [7:0] want;
   always_comb begin
      unique case (mcnt_ff)
         2'd0: want = cur_ff.pattern[7:0];
         2'd1: want = cur_ff.pattern[15:8];
         2'd2: want = cur_ff.pattern[23:16];
         default: want = cur_ff.pattern[31:24];
      endcase
   end

   logic can_start;
   assign can_start = (state_ff == ST_IDLE) && !cmd_empty && !out_v_ff;
   assign cmd_pop   = can_start;

   // Memory read address: peek/pop at issue, search at fetch pointer.
   always_comb begin
      rd_addr = rd_ff[AW-1:0];
      if (state_ff == ST_SEARCH) begin
         rd_addr = AW'(radd(rd_ff, {1'b0, fetch_ff}, size_ff));
      end else if (cmd_data.cmd == CMD_PEEK) begin
         rd_addr = AW'(radd(rd_ff, cnt_ext, size_ff));
      end
   end

   always_ff @(posedge clock) begin
      if (can_start && cmd_data.cmd == CMD_PUSH && (used + 1'b1 < size_ff)) begin
         mem[wr_ff[AW-1:0]] <= cmd_data.data_in;
      end
      rd_q <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff  <= fit(15'(RESET_LEN));
         wr_ff    <= '0;
         rd_ff    <= '0;
         out_v_ff <= 1'b0;
         rd_v_ff  <= 1'b0;
      end else begin
         if (rsp_pop && out_v_ff) out_v_ff <= 1'b0;
         if (csr_we) begin
            size_ff <= fit(csr_wdata);
            wr_ff   <= '0;
            rd_ff   <= '0;
         end else begin
            unique case (state_ff)
               ST_IDLE: begin
                  if (can_start) begin
                     cur_ff   <= cmd_data;
                     o_dat_ff <= 8'd0;
                     o_ok_ff  <= 1'b0;
                     o_amt_ff <= 15'd0;
                     state_ff <= ST_DONE;
                     unique case (cmd_data.cmd)
                        CMD_PUSH: begin
                           if (used + 1'b1 < size_ff) begin
                              wr_ff   <= radd(wr_ff, (SW + 1)'(1), size_ff);
                              o_ok_ff <= 1'b1;
                           end
                        end
                        CMD_POP: begin
                           if (used != 0) begin
                              rd_ff    <= radd(rd_ff, (SW + 1)'(1), size_ff);
                              o_ok_ff  <= 1'b1;
                              state_ff <= ST_READ;
                           end
                        end
                        CMD_PEEK: begin
                           if (cnt_lt_used) begin
                              o_ok_ff  <= 1'b1;
                              state_ff <= ST_READ;
                           end
                        end
                        CMD_DISCARD: begin
                           if (cnt_le_used) begin
                              rd_ff    <= radd(rd_ff, cnt_ext, size_ff);
                              o_amt_ff <= cmd_data.count;
                              o_ok_ff  <= cmd_data.count != 15'd0;
                           end else begin
                              rd_ff    <= wr_ff;
                              o_amt_ff <= 15'(used);
                              o_ok_ff  <= used != 0;
                           end
                        end
                        CMD_SKIP: begin
                           if (cnt_le_used) begin
                              rd_ff    <= radd(rd_ff, cnt_ext, size_ff);
                              o_amt_ff <= cmd_data.count;
                              o_ok_ff  <= 1'b1;
                           end
                        end
                        CMD_SEARCH: begin
                           scan_ff  <= '0;
                           fetch_ff <= '0;
                           mcnt_ff  <= 2'd0;
                           rd_v_ff  <= 1'b0;
                           lim_ff   <= (used > 3) ? used - 3'd3 : '0;
                           state_ff <= (used > 3) ? ST_SEARCH : ST_DONE;
                        end
                        default: ;
                     endcase
                  end
               end
               ST_READ: begin
                  // capture the byte read at issue before the address moves on
                  o_dat_ff <= rd_q;
                  state_ff <= ST_SDRAIN;
               end
               ST_SDRAIN: begin
                  out_v_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
               ST_SEARCH: begin
                  // Read one byte a cycle; compare the byte fetched last cycle.
                  if (rd_v_ff && rd_q != want) begin
                     // restart at next candidate
                     scan_ff  <= scan_ff + 1'b1;
                     fetch_ff <= scan_ff + 1'b1;
                     mcnt_ff  <= 2'd0;
                     rd_v_ff  <= 1'b0;
                     if (scan_ff + 1'b1 >= lim_ff) begin
                        o_amt_ff <= 15'(lim_ff);
                        out_v_ff <= 1'b1;
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     rd_v_ff  <= 1'b1;
                     fetch_ff <= fetch_ff + 1'b1;
                     if (rd_v_ff) begin
                        if (mcnt_ff == 2'd3) begin
                           o_ok_ff  <= 1'b1;
                           o_amt_ff <= 15'(scan_ff);
                           out_v_ff <= 1'b1;
                           state_ff <= ST_IDLE;
                        end else begin
                           mcnt_ff <= mcnt_ff + 1'b1;
                        end
                     end
                  end
               end
               ST_DONE: begin
                  out_v_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end
               default: state_ff <= ST_IDLE;
            endcase
         end
      end
   end

   // Counts are driven combinationally from the ring indexes; no command issues while a result waits.
   assign rsp_used_count = 14'(used_o);
   assign rsp_free_count = 14'(free_o);

   assert property (@(posedge clock) disable iff (reset) used < size_ff)
      else $error("ring holds more than size minus one");
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff && !rsp_pop |=> out_v_ff && $stable(o_amt_ff))
      else $error("result dropped while waiting");
   assert property (@(posedge clock) disable iff (reset)
      out_v_ff |-> !cmd_pop)
      else $error("command issued while result waits");

endmodule

FILE: hdl/byte_ring_fifo_with_search_unit.sv
// Top level of the byte ring FIFO with pattern search.
// Commands enter a two-entry queue through req_push/req_full and are carried
// out one at a time by the engine; results leave through rsp_empty/rsp_pop.
// The engine takes the next item only after the previous result is popped.
// A push, discard, skip or unknown command shows its result through state
// ST_DONE; a pop or peek passes through ST_READ and ST_SDRAIN for one
// registered read of the byte memory. A search compares one byte per cycle
// and refetches after each mismatch: the single read port of the byte
// memory sets that pace.
// Used and free counts shown with a result reflect the ring after that item.
// Write csr_size_in_use only when idle; it empties the ring (0 selects 10240).
module byte_ring_fifo_with_search_unit
   import brf_pkg::*;
#(
   parameter int unsigned DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [2:0]  req_cmd,
   input  logic [7:0]  req_data_in,
   input  logic [14:0] req_count,
   input  logic [31:0] req_pattern,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_data_out,
   output logic        rsp_ok,
   output logic [14:0] rsp_amount,
   output logic [13:0] rsp_used_count,
   output logic [13:0] rsp_free_count,
   input  logic        csr_we,
   input  logic [14:0] csr_size_in_use
);

   entry_type q_in, q_out;
   logic      q_empty, q_pop, eng_busy;

   // Pack the command fields into one queue entry.
   assign q_in = '{cmd: req_cmd, data_in: req_data_in, count: req_count,
                   pattern: req_pattern};

   brf_cmd_queue u_queue (
      .clock, .reset,
      .push(req_push), .push_data(q_in), .full(req_full),
      .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   brf_engine #(.DEPTH(DEPTH)) u_engine (
      .clock, .reset,
      .csr_we, .csr_wdata(csr_size_in_use),
      .cmd_data(q_out), .cmd_empty(q_empty), .cmd_pop(q_pop),
      .rsp_empty, .rsp_pop, .rsp_data_out, .rsp_ok, .rsp_amount,
      .rsp_used_count, .rsp_free_count, .busy(eng_busy)
   );

   assert property (@(posedge clock) disable iff (reset)
      eng_busy || q_empty || !q_pop)
      else $error("queue popped while engine idle and queue empty");
   assert property (@(posedge clock) disable iff (reset)
      req_full |-> eng_busy)
      else $error("queue full without pending work");
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("result withdrawn before pop");

endmodule
